>>> rtl/core/lfp_pkg.sv
// Shared types and constants for the ranging sensor frame parser.
// No dependencies; every module of the parser imports this package.
package lfp_pkg;

    // Frame header byte, sent twice at the start of each frame.
    localparam logic [7:0] HDR_BYTE = 8'h59;

    // Body bytes per frame: six data bytes and one checksum byte.
    localparam int BODY_LEN  = 7;
    localparam int DATA_LEN  = 6;
    localparam int IDX_W     = $clog2(BODY_LEN);

    // Sync phase codes.
    localparam logic [1:0] PHASE_HUNT    = 2'd0;
    localparam logic [1:0] PHASE_CONFIRM = 2'd1;
    localparam logic [1:0] PHASE_BODY    = 2'd2;

    // Configuration register indexes and reset values.
    localparam int          CFG_W         = 15;
    localparam logic        REG_MIN_DIST  = 1'b0;
    localparam logic        REG_FALLBACK  = 1'b1;
    localparam logic [14:0] MIN_DIST_RST  = 15'd2;
    localparam logic [14:0] FALLBACK_RST  = 15'd1300;

    // Width of the temperature result.
    localparam int TEMP_W = 14;

    // Collected frame as seen by the result stage.
    typedef struct packed {
        logic               last;
        logic signed [15:0] dist_word;
        logic signed [15:0] strength;
        logic signed [15:0] temp_raw;
    } frame_t;

    // Configuration values handed to the result stage.
    typedef struct packed {
        logic [CFG_W-1:0] min_dist;
        logic [CFG_W-1:0] fallback;
    } cfg_t;

endpackage

>>> rtl/core/lfp_cfg_regs.sv
// APB-style configuration registers of the frame parser.
// Depends on lfp_pkg for register indexes, widths and reset values.
module lfp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output lfp_pkg::cfg_t cfg
);
    import lfp_pkg::*;

    logic [CFG_W-1:0] min_dist_reg;
    logic [CFG_W-1:0] fallback_reg;
    logic             wr_en;
    logic             reg_sel;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes; only the low fifteen data bits are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RST;
            fallback_reg <= FALLBACK_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_MIN_DIST)
            begin
                min_dist_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                fallback_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Read data, zero extended.
    always_comb
    begin
        if (reg_sel == REG_FALLBACK)
        begin
            prdata = {{(32-CFG_W){1'b0}}, fallback_reg};
        end
        else
        begin
            prdata = {{(32-CFG_W){1'b0}}, min_dist_reg};
        end
    end

    assign cfg.min_dist = min_dist_reg;
    assign cfg.fallback = fallback_reg;

endmodule

>>> rtl/core/lfp_frame_sync.sv
// Header hunt and body collection of the frame parser.
// Depends on lfp_pkg for the header byte, phase codes and the frame type.
module lfp_frame_sync (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    output lfp_pkg::frame_t frame
);
    import lfp_pkg::*;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [7:0]       body_reg [DATA_LEN];
    logic             is_last;

    // The checksum byte is the last body byte of a frame.
    assign is_last = (phase_reg == PHASE_BODY) && (index_reg == IDX_W'(DATA_LEN));

    // Phase and body index transitions for one accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        case (phase_reg)
            PHASE_CONFIRM:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    phase_next = PHASE_BODY;
                    index_next = '0;
                end
                else
                begin
                    phase_next = PHASE_HUNT;
                end
            end
            PHASE_BODY:
            begin
                if (is_last)
                begin
                    phase_next = PHASE_HUNT;
                    index_next = '0;
                end
                else
                begin
                    index_next = index_reg + IDX_W'(1);
                end
            end
            default:
            begin
                phase_next = (rx_byte == HDR_BYTE) ? PHASE_CONFIRM : PHASE_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_HUNT;
            index_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

    // Data bytes are stored as they arrive; the checksum is dropped.
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PHASE_BODY) && !is_last)
        begin
            body_reg[index_reg] <= rx_byte;
        end
    end

    // Little-endian words from the stored bytes.
    assign frame.last      = is_last;
    assign frame.dist_word = $signed({body_reg[1], body_reg[0]});
    assign frame.strength  = $signed({body_reg[3], body_reg[2]});
    assign frame.temp_raw  = $signed({body_reg[5], body_reg[4]});

    // The body index only moves while a body is being collected.
    a_index_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (index_reg != '0) |-> (phase_reg == PHASE_BODY))
        else $error("body index nonzero outside body phase");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IDX_W'(DATA_LEN))
        else $error("body index past checksum byte");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (phase_reg == PHASE_HUNT) && (index_reg == '0))
        else $error("hunt did not restart after checksum byte");

endmodule

>>> rtl/core/lfp_result_reg.sv
// Result conversion and output register of the frame parser.
// Depends on lfp_pkg for the frame and configuration types.
module lfp_result_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  lfp_pkg::frame_t           frame,
    input  lfp_pkg::cfg_t             cfg,
    input  logic                      res_ready,
    output logic                      res_valid,
    output logic signed [15:0]        distance_cm,
    output logic                      distance_replaced,
    output logic signed [15:0]        signal_strength,
    output logic signed [lfp_pkg::TEMP_W-1:0] temperature
);
    import lfp_pkg::*;

    logic                     valid_reg;
    logic signed [15:0]       dist_reg;
    logic                     repl_reg;
    logic signed [15:0]       str_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic                     repl_next;
    logic signed [15:0]       dist_next;
    logic signed [16:0]       temp_adj;
    logic signed [TEMP_W-1:0] temp_quot;
    logic signed [TEMP_W-1:0] temp_next;

    // Fallback substitution for readings below the minimum distance.
    assign repl_next = frame.dist_word < $signed({1'b0, cfg.min_dist});
    assign dist_next = repl_next ? $signed({1'b0, cfg.fallback}) : frame.dist_word;

    // Divide by eight toward zero: bias negative words before the shift.
    assign temp_adj  = {frame.temp_raw[15], frame.temp_raw}
                     + $signed({14'd0, {3{frame.temp_raw[15]}}});
    assign temp_quot = temp_adj[16:3];
    assign temp_next = temp_quot - TEMP_W'(256);

    // Output valid: set by a new frame, cleared when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dist_reg <= dist_next;
            repl_reg <= repl_next;
            str_reg  <= frame.strength;
            temp_reg <= temp_next;
        end
    end

    assign res_valid         = valid_reg;
    assign distance_cm       = dist_reg;
    assign distance_replaced = repl_reg;
    assign signal_strength   = str_reg;
    assign temperature       = temp_reg;

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && !res_ready))
        else $error("result overwritten before its transaction");

    // Loading only happens on the checksum byte of a frame.
    a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> frame.last)
        else $error("result loaded outside the last body byte");

    // A reading that is kept, not replaced, is never below the minimum distance it was tested against.
    a_kept_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !repl_next) |=> (distance_cm >= $signed({1'b0, $past(cfg.min_dist)})))
        else $error("reading below minimum passed through");

endmodule

>>> rtl/core/lidar_frame_parser_unit.sv
// Top level of the ranging sensor frame parser.
// Depends on lfp_pkg, lfp_cfg_regs, lfp_frame_sync and lfp_result_reg.

// The parser takes one received serial byte per clock cycle while it is not
// stalled on a checksum byte. It hunts for the two header bytes 0x59 0x59,
// collects seven body bytes, and in the cycle after the checksum byte (ninth
// byte of a frame) is accepted presents a result: distance in centimeters
// (replaced by the fallback register when below the minimum register), the
// raw strength, and temperature as raw/8 truncated toward zero minus 256. The
// checksum is not verified. Each accepted byte moves the header/body
// sequencer by one step; one result register holds a finished frame, and only
// the checksum byte of the next frame waits while that result is still untaken.
// Registers: min_distance_cm at byte address 0, fallback_distance_cm at 4.
module lidar_frame_parser_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  logic [7:0]                rx_byte,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic signed [15:0]        distance_cm,
    output logic                      distance_replaced,
    output logic signed [15:0]        signal_strength,
    output logic signed [lfp_pkg::TEMP_W-1:0] temperature
);
    import lfp_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   accept;
    logic   load;

    // Only the checksum byte produces a result, so only it waits on the output.
    assign rx_ready = !frame.last || !res_valid || res_ready;
    assign accept   = rx_valid && rx_ready;
    assign load     = accept && frame.last;

    lfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfp_frame_sync u_sync (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    lfp_result_reg u_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (load),
        .frame             (frame),
        .cfg               (cfg),
        .res_ready         (res_ready),
        .res_valid         (res_valid),
        .distance_cm       (distance_cm),
        .distance_replaced (distance_replaced),
        .signal_strength   (signal_strength),
        .temperature       (temperature)
    );

endmodule
